// File: rtl/torque_autobias_lut_interp_unit_assert.svh
// assertion macros used by the checker file
`ifndef TORQUE_AUTOBIAS_LUT_INTERP_UNIT_ASSERT_SVH
`define TORQUE_AUTOBIAS_LUT_INTERP_UNIT_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define TALI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define TALI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/tali_pkg.sv
package tali_pkg;

  localparam int LUT_POINTS = 8;
  localparam int ADC_WIDTH  = 10;

  localparam int NM_W      = 15;
  localparam int TIME_W    = 32;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int OKMIN_W   = 10;
  localparam int CMP_W     = 16;
  localparam int TAB_IDX_W = 4;
  localparam int IDX_W     = (LUT_POINTS > 2) ? $clog2(LUT_POINTS) : 1;
  localparam int NUM_W     = ADC_WIDTH + NM_W;
  localparam int CNT_W     = $clog2(NM_W);

  localparam logic [TAB_IDX_W-1:0] LAST_IDX = TAB_IDX_W'(LUT_POINTS - 1);

  localparam logic [CFG_W-1:0]   START_RST  = CFG_W'(2000);
  localparam logic [CFG_W-1:0]   DUR_RST    = CFG_W'(3000);
  localparam logic [OKMIN_W-1:0] OKMIN_RST  = OKMIN_W'(50);
  localparam logic [NM_W-1:0]    TORQUE_MAX = NM_W'(17511);

  localparam logic [CFG_IDX_W-1:0] REG_BIAS_START = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BIAS_DUR   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_BIAS_OKMIN = CFG_IDX_W'(2);

  typedef enum logic [1:0] {
    C_IDLE,
    C_EVAL,
    C_INTERP,
    C_OUT
  } ctrl_state_t;

  typedef enum logic [2:0] {
    I_IDLE,
    I_SEARCH,
    I_MUL,
    I_DIV,
    I_FIN
  } interp_state_t;

  typedef struct packed {
    logic                 start;
    logic [ADC_WIDTH-1:0] x;
  } interp_req_t;

  typedef struct packed {
    logic            done;
    logic [NM_W-1:0] y;
  } interp_rsp_t;

  function automatic logic [ADC_WIDTH-1:0] lut_adc(input logic [TAB_IDX_W-1:0] i);
    logic [ADC_WIDTH-1:0] v;
    case (i)
      4'd0:    v = ADC_WIDTH'(0);
      4'd1:    v = ADC_WIDTH'(30);
      4'd2:    v = ADC_WIDTH'(55);
      4'd3:    v = ADC_WIDTH'(78);
      4'd4:    v = ADC_WIDTH'(93);
      4'd5:    v = ADC_WIDTH'(188);
      4'd6:    v = ADC_WIDTH'(204);
      default: v = ADC_WIDTH'(224);
    endcase
    return v;
  endfunction

  function automatic logic [NM_W-1:0] lut_nm(input logic [TAB_IDX_W-1:0] i);
    logic [NM_W-1:0] v;
    case (i)
      4'd0:    v = NM_W'(0);
      4'd1:    v = NM_W'(834);
      4'd2:    v = NM_W'(1668);
      4'd3:    v = NM_W'(2502);
      4'd4:    v = NM_W'(3169);
      4'd5:    v = NM_W'(7004);
      4'd6:    v = NM_W'(8672);
      default: v = NM_W'(17511);
    endcase
    return v;
  endfunction

endpackage

// File: rtl/tali_if.sv
interface tali_in_if;
  logic                           valid;
  logic                           ready;
  logic [tali_pkg::TIME_W-1:0]    now_ms;
  logic [tali_pkg::ADC_WIDTH-1:0] adc_sample;
  modport source (output valid, now_ms, adc_sample, input ready);
  modport sink (input valid, now_ms, adc_sample, output ready);
endinterface

interface tali_out_if;
  logic                           valid;
  logic                           ready;
  logic [tali_pkg::NM_W-1:0]      torque_cnm;
  logic [tali_pkg::ADC_WIDTH-1:0] bias_value;
  logic                           calibrated;
  logic                           calib_event;
  logic                           sensor_ok;
  modport source (output valid, torque_cnm, bias_value, calibrated, calib_event,
                  sensor_ok, input ready);
  modport sink (input valid, torque_cnm, bias_value, calibrated, calib_event,
                sensor_ok, output ready);
endinterface

interface tali_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tali_pkg::CFG_IDX_W-1:0] index;
  logic [tali_pkg::CFG_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/tali_interp.sv
module tali_interp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tali_pkg::interp_req_t req,
  output tali_pkg::interp_rsp_t rsp
);

  tali_pkg::interp_state_t state_r, state_nxt;

  logic [tali_pkg::IDX_W-1:0]     idx_r, idx_nxt;
  logic [tali_pkg::ADC_WIDTH-1:0] x_r, x_nxt;
  logic [tali_pkg::ADC_WIDTH-1:0] dx_r, dx_nxt;
  logic [tali_pkg::NM_W-1:0]      dy_r, dy_nxt;
  logic [tali_pkg::ADC_WIDTH-1:0] span_r, span_nxt;
  logic [tali_pkg::NM_W-1:0]      y0_r, y0_nxt;
  logic [tali_pkg::ADC_WIDTH-1:0] rem_r, rem_nxt;
  logic [tali_pkg::NM_W-1:0]      num_r, num_nxt;
  logic [tali_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [tali_pkg::NM_W-1:0]      y_r, y_nxt;

  logic [tali_pkg::IDX_W-1:0]     idx_inc;
  logic [tali_pkg::ADC_WIDTH-1:0] a0, a1, seg_span;
  logic [tali_pkg::NM_W-1:0]      n0, n1;
  logic [tali_pkg::NUM_W-1:0]     prod;
  logic [tali_pkg::ADC_WIDTH:0]   trial;
  logic                           qbit;
  logic [tali_pkg::NM_W-1:0]      quot;

  assign idx_inc  = idx_r + tali_pkg::IDX_W'(1);
  assign a0       = tali_pkg::lut_adc(tali_pkg::TAB_IDX_W'(idx_r));
  assign a1       = tali_pkg::lut_adc(tali_pkg::TAB_IDX_W'(idx_inc));
  assign n0       = tali_pkg::lut_nm(tali_pkg::TAB_IDX_W'(idx_r));
  assign n1       = tali_pkg::lut_nm(tali_pkg::TAB_IDX_W'(idx_inc));
  assign seg_span = a1 - a0;
  assign prod     = tali_pkg::NUM_W'(dx_r) * tali_pkg::NUM_W'(dy_r);
  assign trial    = {rem_r, num_r[tali_pkg::NM_W-1]};
  assign qbit     = (trial >= {1'b0, span_r});
  assign quot     = {num_r[tali_pkg::NM_W-2:0], qbit};

  assign rsp.done = (state_r == tali_pkg::I_FIN);
  assign rsp.y    = y_r;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    x_nxt     = x_r;
    dx_nxt    = dx_r;
    dy_nxt    = dy_r;
    span_nxt  = span_r;
    y0_nxt    = y0_r;
    rem_nxt   = rem_r;
    num_nxt   = num_r;
    cnt_nxt   = cnt_r;
    y_nxt     = y_r;
    case (state_r)
      tali_pkg::I_IDLE: begin
        if (req.start) begin
          x_nxt   = req.x;
          idx_nxt = '0;
          if (req.x >= tali_pkg::lut_adc(tali_pkg::LAST_IDX)) begin
            y_nxt     = tali_pkg::lut_nm(tali_pkg::LAST_IDX);
            state_nxt = tali_pkg::I_FIN;
          end else begin
            state_nxt = tali_pkg::I_SEARCH;
          end
        end
      end
      tali_pkg::I_SEARCH: begin
        if (a1 > x_r) begin
          if (seg_span == '0 || n1 < n0) begin
            y_nxt     = n0;
            state_nxt = tali_pkg::I_FIN;
          end else begin
            dx_nxt    = x_r - a0;
            dy_nxt    = n1 - n0;
            span_nxt  = seg_span;
            y0_nxt    = n0;
            state_nxt = tali_pkg::I_MUL;
          end
        end else begin
          idx_nxt = idx_inc;
        end
      end
      tali_pkg::I_MUL: begin
        rem_nxt   = prod[tali_pkg::NUM_W-1:tali_pkg::NM_W];
        num_nxt   = prod[tali_pkg::NM_W-1:0];
        cnt_nxt   = tali_pkg::CNT_W'(tali_pkg::NM_W - 1);
        state_nxt = tali_pkg::I_DIV;
      end
      tali_pkg::I_DIV: begin
        rem_nxt = qbit ? tali_pkg::ADC_WIDTH'(trial - {1'b0, span_r})
                       : trial[tali_pkg::ADC_WIDTH-1:0];
        num_nxt = quot;
        cnt_nxt = cnt_r - tali_pkg::CNT_W'(1);
        if (cnt_r == '0) begin
          y_nxt     = y0_r + quot;
          state_nxt = tali_pkg::I_FIN;
        end
      end
      tali_pkg::I_FIN: begin
        state_nxt = tali_pkg::I_IDLE;
      end
      default: begin
        state_nxt = tali_pkg::I_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tali_pkg::I_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    x_r    <= x_nxt;
    dx_r   <= dx_nxt;
    dy_r   <= dy_nxt;
    span_r <= span_nxt;
    y0_r   <= y0_nxt;
    rem_r  <= rem_nxt;
    num_r  <= num_nxt;
    cnt_r  <= cnt_nxt;
    y_r    <= y_nxt;
  end

endmodule

// File: rtl/torque_autobias_lut_interp_unit.sv
// channel   dir  handshake     payload
// in_ch     in   valid/ready   now_ms[31:0], adc_sample[9:0]
// out_ch    out  valid/ready   torque_cnm[14:0], bias_value[9:0], calibrated,
//                              calib_event, sensor_ok
// cfg_ch    in   valid/ready   index[1:0], data[15:0]; ready always high
//
// before calibration an accepted sample goes from idle through C_EVAL to C_OUT
// after calibration the interpolator runs: one table compare per segment step (up to 7),
// one multiply and a serial divide of 15 quotient bits; a clamped input skips these
// in_ready is high only while the sequencer is idle; one transaction at a time
// a stalled result holds the sequencer until out_ch.ready
// rst_n is synchronous; configuration resets to 2000 / 3000 / 50
module torque_autobias_lut_interp_unit (
  input logic        clk,
  input logic        rst_n,
  tali_in_if.sink    in_ch,
  tali_out_if.source out_ch,
  tali_cfg_if.sink   cfg_ch
);

  tali_pkg::ctrl_state_t state_r, state_nxt;

  logic [tali_pkg::CFG_W-1:0]     start_r, start_nxt;
  logic [tali_pkg::CFG_W-1:0]     dur_r, dur_nxt;
  logic [tali_pkg::OKMIN_W-1:0]   okmin_r, okmin_nxt;
  logic                           bias_done_r, bias_done_nxt;
  logic [tali_pkg::ADC_WIDTH-1:0] bias_level_r, bias_level_nxt;
  logic [tali_pkg::NM_W-1:0]      torque_hold_r, torque_hold_nxt;
  logic                           event_r, event_nxt;
  logic [tali_pkg::TIME_W-1:0]    now_r, now_nxt;
  logic [tali_pkg::ADC_WIDTH-1:0] sample_r, sample_nxt;

  logic                           out_valid_r, out_valid_nxt;
  logic [tali_pkg::NM_W-1:0]      out_torque_r, out_torque_nxt;
  logic [tali_pkg::ADC_WIDTH-1:0] out_bias_r, out_bias_nxt;
  logic                           out_cal_r, out_cal_nxt;
  logic                           out_event_r, out_event_nxt;
  logic                           out_ok_r, out_ok_nxt;

  logic                           in_ready;
  logic [tali_pkg::CFG_W:0]       win_end;
  tali_pkg::interp_req_t          req;
  tali_pkg::interp_rsp_t          rsp;

  tali_interp u_interp (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  assign win_end = {1'b0, start_r} + {1'b0, dur_r};

  assign in_ch.ready        = in_ready;
  assign cfg_ch.ready       = 1'b1;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.torque_cnm  = out_torque_r;
  assign out_ch.bias_value  = out_bias_r;
  assign out_ch.calibrated  = out_cal_r;
  assign out_ch.calib_event = out_event_r;
  assign out_ch.sensor_ok   = out_ok_r;

  always_comb begin
    state_nxt       = state_r;
    start_nxt       = start_r;
    dur_nxt         = dur_r;
    okmin_nxt       = okmin_r;
    bias_done_nxt   = bias_done_r;
    bias_level_nxt  = bias_level_r;
    torque_hold_nxt = torque_hold_r;
    event_nxt       = event_r;
    now_nxt         = now_r;
    sample_nxt      = sample_r;
    out_valid_nxt   = out_valid_r;
    out_torque_nxt  = out_torque_r;
    out_bias_nxt    = out_bias_r;
    out_cal_nxt     = out_cal_r;
    out_event_nxt   = out_event_r;
    out_ok_nxt      = out_ok_r;
    in_ready        = 1'b0;
    req.start       = 1'b0;
    req.x           = '0;

    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        tali_pkg::REG_BIAS_START: start_nxt = cfg_ch.data;
        tali_pkg::REG_BIAS_DUR:   dur_nxt   = cfg_ch.data;
        tali_pkg::REG_BIAS_OKMIN: okmin_nxt = cfg_ch.data[tali_pkg::OKMIN_W-1:0];
        default: ;
      endcase
    end

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      tali_pkg::C_IDLE: begin
        in_ready = 1'b1;
        if (in_ch.valid) begin
          now_nxt    = in_ch.now_ms;
          sample_nxt = in_ch.adc_sample;
          state_nxt  = tali_pkg::C_EVAL;
        end
      end
      tali_pkg::C_EVAL: begin
        event_nxt = 1'b0;
        if (bias_done_r) begin
          req.start = 1'b1;
          req.x     = (sample_r > bias_level_r) ? sample_r - bias_level_r : '0;
          state_nxt = tali_pkg::C_INTERP;
        end else begin
          if (now_r < tali_pkg::TIME_W'(win_end)) begin
            if (now_r > tali_pkg::TIME_W'(start_r) && sample_r > bias_level_r) begin
              bias_level_nxt = sample_r;
            end
          end else begin
            bias_done_nxt = 1'b1;
            event_nxt     = 1'b1;
          end
          state_nxt = tali_pkg::C_OUT;
        end
      end
      tali_pkg::C_INTERP: begin
        if (rsp.done) begin
          torque_hold_nxt = rsp.y;
          state_nxt       = tali_pkg::C_OUT;
        end
      end
      tali_pkg::C_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_torque_nxt = torque_hold_r;
          out_bias_nxt   = bias_level_r;
          out_cal_nxt    = bias_done_r;
          out_event_nxt  = event_r;
          out_ok_nxt     = !bias_done_r ||
                           (tali_pkg::CMP_W'(bias_level_r) > tali_pkg::CMP_W'(okmin_r));
          state_nxt      = tali_pkg::C_IDLE;
        end
      end
      default: begin
        state_nxt = tali_pkg::C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= tali_pkg::C_IDLE;
      start_r       <= tali_pkg::START_RST;
      dur_r         <= tali_pkg::DUR_RST;
      okmin_r       <= tali_pkg::OKMIN_RST;
      bias_done_r   <= 1'b0;
      bias_level_r  <= '0;
      torque_hold_r <= '0;
      event_r       <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      start_r       <= start_nxt;
      dur_r         <= dur_nxt;
      okmin_r       <= okmin_nxt;
      bias_done_r   <= bias_done_nxt;
      bias_level_r  <= bias_level_nxt;
      torque_hold_r <= torque_hold_nxt;
      event_r       <= event_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    now_r        <= now_nxt;
    sample_r     <= sample_nxt;
    out_torque_r <= out_torque_nxt;
    out_bias_r   <= out_bias_nxt;
    out_cal_r    <= out_cal_nxt;
    out_event_r  <= out_event_nxt;
    out_ok_r     <= out_ok_nxt;
  end

endmodule

// File: rtl/tali_chk.sv
`include "torque_autobias_lut_interp_unit_assert.svh"

module tali_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [tali_pkg::NM_W-1:0]      torque,
  input logic                           calibrated,
  input logic                           calib_event,
  input logic                           sensor_ok
);

  logic seen_cal_r, seen_cal_nxt;
  logic in_fire;

  assign in_fire      = in_valid && in_ready;
  assign seen_cal_nxt = seen_cal_r || (out_valid && out_ready && calibrated);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_cal_r <= 1'b0;
    end else begin
      seen_cal_r <= seen_cal_nxt;
    end
  end

  // calibration event only together with calibrated
  `TALI_ASSERT_NOW(a_event_cal, out_valid && calib_event, calibrated, "event without calibrated")

  // before calibration torque stays zero and the sensor reads ok
  `TALI_ASSERT_NOW(a_precal, out_valid && !calibrated, sensor_ok && torque == '0, "precal output wrong")

  // calibration is sticky and its event is raised once
  `TALI_ASSERT_NOW(a_cal_sticky, out_valid && seen_cal_r, calibrated && !calib_event, "calibration lost or event repeated")

  `TALI_ASSERT_NOW(a_torque_max, out_valid, torque <= tali_pkg::TORQUE_MAX, "torque above table maximum")

  // one transaction in flight at a time
  `TALI_ASSERT_NEXT(a_busy, in_fire, !in_ready, "input taken while busy")

endmodule

bind torque_autobias_lut_interp_unit tali_chk u_tali_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .torque      (out_ch.torque_cnm),
  .calibrated  (out_ch.calibrated),
  .calib_event (out_ch.calib_event),
  .sensor_ok   (out_ch.sensor_ok)
);
